// ----- src/i2cram_pkg.sv -----
`default_nettype none
package i2cram_pkg;

  // bits per byte on the bus
  localparam int unsigned BYTE_BITS = 8;
  localparam int unsigned BIT_IDX_W = 4;

  // last byte position of a transaction
  localparam logic [2:0] SLOT_LAST = 3'd7;

  // configuration register indexes
  localparam logic REG_DEVICE_ADDRESS = 1'b0;
  localparam logic REG_HALF_PERIOD    = 1'b1;

  // configuration reset values
  localparam logic [6:0] DEV_ADDR_RESET = 7'd81;
  localparam logic [7:0] HALF_RESET     = 8'd2;

  // action codes
  localparam logic ACT_READ  = 1'b0;
  localparam logic ACT_WRITE = 1'b1;

  // packed widths of the stream payloads
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  // waveform steps
  typedef enum logic [2:0] {
    ST_IDLE        = 3'd0,
    ST_START_SETUP = 3'd1,
    ST_START_HOLD  = 3'd2,
    ST_LO_HOLD     = 3'd3,
    ST_LO_SET      = 3'd4,
    ST_HI          = 3'd5,
    ST_STOP_HI     = 3'd6,
    ST_STOP_REL    = 3'd7
  } step_t;

  // what a byte position does on the bus
  typedef enum logic [1:0] {
    KIND_TX   = 2'd0,
    KIND_RX   = 2'd1,
    KIND_RS   = 2'd2,
    KIND_STOP = 2'd3
  } kind_t;

  // one decoded tick item
  typedef struct packed {
    logic       start_request;
    logic       action;
    logic [7:0] reg_address;
    logic [7:0] write_data;
    logic       sda_in;
  } item_t;

  // one tick result
  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } result_t;

  // configuration seen by the bus engine
  typedef struct packed {
    logic [6:0] device_address;
    logic [7:0] half_period_ticks;
  } cfg_t;

endpackage
`default_nettype wire

// ----- src/i2c_register_access_master_top.sv -----
// channel | direction | handshake           | payload
// in_     | slave     | in_tvalid/in_tready | in_tdata: one bus tick of request and sda sample
// out_    | master    | out_tvalid/tready   | out_tdata: line drives, status, read byte
// cfg_    | apb slave | psel/penable/pready | device_address at 0, half_period_ticks at 4
//
// one result per tick item; an item is stored in the two-entry input queue, then
// the engine works it out and loads the output register, so its result is offered
// from the output register once the item has left the queue register
// the sustained rate is one item per cycle while out_ is not stalled, set by the bus step engine
// reset (rst_n low, synchronous) empties the queue and output register and parks
// the bus released; a stall on out_ holds the engine while the queue fills
`default_nettype none
module i2c_register_access_master_top (
  input  wire         clk,
  input  wire         rst_n,
  // start_request[0], action[1], reg_address[9:2], write_data[17:10], sda_in[18]
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [23:0] in_tdata,
  // scl_out[0], sda_out[1], busy_res[2], done_res[3], read_data[11:4]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata,
  input  wire         cfg_psel,
  input  wire         cfg_penable,
  input  wire         cfg_pwrite,
  input  wire  [2:0]  cfg_paddr,
  input  wire  [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [6:0] dev_addr_r;
  logic [7:0] half_r;
  logic       cfg_wr;
  logic       reg_idx;
  logic       q_valid;
  logic       q_pop;
  i2cram_pkg::item_t q_item;
  i2cram_pkg::cfg_t  cfg;

  // register port
  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_addr_r <= i2cram_pkg::DEV_ADDR_RESET;
      half_r     <= i2cram_pkg::HALF_RESET;
    end else if (cfg_wr) begin
      if (reg_idx == i2cram_pkg::REG_DEVICE_ADDRESS) begin
        dev_addr_r <= cfg_pwdata[6:0];
      end else begin
        half_r <= cfg_pwdata[7:0];
      end
    end
  end

  always_comb begin
    case (reg_idx)
      i2cram_pkg::REG_DEVICE_ADDRESS: cfg_prdata = {25'd0, dev_addr_r};
      i2cram_pkg::REG_HALF_PERIOD:    cfg_prdata = {24'd0, half_r};
      default:                        cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.device_address    = dev_addr_r;
  assign cfg.half_period_ticks = half_r;

  // input side and queue
  i2cram_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_item    (q_item)
  );

  // bus engine and output register
  i2cram_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule
`default_nettype wire

// ----- src/i2cram_front.sv -----
`default_nettype none
module i2cram_front (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_tvalid,
  output logic                                  in_tready,
  input  wire  [i2cram_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                                  q_valid,
  input  wire                                   q_pop,
  output i2cram_pkg::item_t                     q_item
);

  i2cram_pkg::item_t entry_r [2];
  i2cram_pkg::item_t entry_nxt;
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  logic       pop;

  // unpack the transaction into its fields
  always_comb begin
    entry_nxt.start_request = in_tdata[0];
    entry_nxt.action        = in_tdata[1];
    entry_nxt.reg_address   = in_tdata[9:2];
    entry_nxt.write_data    = in_tdata[17:10];
    entry_nxt.sda_in        = in_tdata[18];
  end

  // two-entry queue control
  assign in_tready = (count_r != 2'd2);
  assign q_valid   = (count_r != 2'd0);
  assign q_item    = entry_r[rd_ptr_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= entry_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- src/i2cram_back.sv -----
`default_nettype none
module i2cram_back (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire  i2cram_pkg::cfg_t                cfg,
  input  wire                                   q_valid,
  output logic                                  q_pop,
  input  wire  i2cram_pkg::item_t               q_item,
  output logic                                  out_tvalid,
  input  wire                                   out_tready,
  output logic [i2cram_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  // kind of the current byte position
  function automatic i2cram_pkg::kind_t slot_kind(input logic act, input logic [2:0] slot);
    i2cram_pkg::kind_t k;
    k = i2cram_pkg::KIND_STOP;
    if (act == i2cram_pkg::ACT_WRITE) begin
      if (slot <= 3'd2) k = i2cram_pkg::KIND_TX;
    end else begin
      case (slot) inside
        3'd0, 3'd1, 3'd3: k = i2cram_pkg::KIND_TX;
        3'd2:             k = i2cram_pkg::KIND_RS;
        3'd4:             k = i2cram_pkg::KIND_RX;
        default:          k = i2cram_pkg::KIND_STOP;
      endcase
    end
    return k;
  endfunction

  // byte loaded into the shifter for a byte position
  function automatic logic [7:0] slot_load(input logic act, input logic [2:0] slot,
                                           input logic [7:0] regb, input logic [7:0] datab,
                                           input logic [6:0] addr);
    logic [7:0] w;
    logic [7:0] b;
    w = {addr, 1'b0};
    b = 8'd0;
    if (slot == 3'd0) b = w;
    else if (slot == 3'd1) b = regb;
    else if (act == i2cram_pkg::ACT_WRITE && slot == 3'd2) b = datab;
    else if (act == i2cram_pkg::ACT_READ && slot == 3'd3) b = w | 8'h01;
    return b;
  endfunction

  i2cram_pkg::step_t step_r, step_nxt, step_e;
  logic [7:0] phase_r, phase_nxt, phase_e;
  logic [i2cram_pkg::BIT_IDX_W-1:0] bit_r, bit_nxt, bit_e;
  logic [7:0] shift_r, shift_nxt, shift_e;
  logic       act_r, act_nxt;
  logic [7:0] regb_r, regb_nxt;
  logic [7:0] datab_r, datab_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic [2:0] slot_r, slot_nxt, slot_e, slot_inc;
  logic       sda_lvl_r, sda_lvl_nxt;
  logic       out_valid_r;
  i2cram_pkg::result_t res_r, res_nxt;
  i2cram_pkg::kind_t kind;
  logic       take;
  logic       slot_sda;
  logic [8:0] tick;
  logic [7:0] h;
  logic [7:0] shift_rx;

  assign q_pop = q_valid && (!out_valid_r || out_tready);

  // request acceptance and effective state for this tick
  always_comb begin
    take      = (step_r == i2cram_pkg::ST_IDLE) && q_item.start_request;
    act_nxt   = take ? q_item.action : act_r;
    regb_nxt  = take ? q_item.reg_address : regb_r;
    datab_nxt = take ? q_item.write_data : datab_r;
    slot_e    = take ? 3'd0 : slot_r;
    bit_e     = take ? '0 : bit_r;
    shift_e   = take ? {cfg.device_address, 1'b0} : shift_r;
    phase_e   = take ? 8'd0 : phase_r;
    step_e    = take ? i2cram_pkg::ST_START_SETUP : step_r;
    kind      = slot_kind(act_nxt, slot_e);
    slot_inc  = (slot_e < i2cram_pkg::SLOT_LAST) ? slot_e + 3'd1 : slot_e;
    shift_rx  = {shift_e[6:0], q_item.sda_in};
    h         = (cfg.half_period_ticks != 8'd0) ? cfg.half_period_ticks : 8'd1;
    tick      = {1'b0, phase_e} + 9'd1;
  end

  // data line level within a bit slot
  always_comb begin
    case (kind)
      i2cram_pkg::KIND_TX:
        slot_sda = (bit_e < i2cram_pkg::BIT_IDX_W'(i2cram_pkg::BYTE_BITS)) ? shift_e[7] : 1'b1;
      i2cram_pkg::KIND_STOP: slot_sda = 1'b0;
      default:               slot_sda = 1'b1;
    endcase
  end

  // line drives and status for this tick
  always_comb begin
    res_nxt = '0;
    case (step_e)
      i2cram_pkg::ST_IDLE:        begin res_nxt.scl_out = 1'b1; res_nxt.sda_out = 1'b1; end
      i2cram_pkg::ST_START_SETUP: begin res_nxt.scl_out = 1'b1; res_nxt.sda_out = 1'b1; end
      i2cram_pkg::ST_START_HOLD:  begin res_nxt.scl_out = 1'b1; res_nxt.sda_out = 1'b0; end
      i2cram_pkg::ST_LO_HOLD:     begin res_nxt.scl_out = 1'b0; res_nxt.sda_out = sda_lvl_r; end
      i2cram_pkg::ST_LO_SET:      begin res_nxt.scl_out = 1'b0; res_nxt.sda_out = slot_sda; end
      i2cram_pkg::ST_HI:          begin res_nxt.scl_out = 1'b1; res_nxt.sda_out = slot_sda; end
      i2cram_pkg::ST_STOP_HI:     begin res_nxt.scl_out = 1'b1; res_nxt.sda_out = 1'b0; end
      i2cram_pkg::ST_STOP_REL:    begin res_nxt.scl_out = 1'b1; res_nxt.sda_out = 1'b1; end
      default:                    begin res_nxt.scl_out = 1'b1; res_nxt.sda_out = 1'b1; end
    endcase
    res_nxt.busy_res = (step_e != i2cram_pkg::ST_IDLE);
    res_nxt.done_res = (step_e == i2cram_pkg::ST_STOP_REL) && (tick >= {1'b0, h});
    res_nxt.read_data = rx_nxt;
  end

  // step sequencing
  always_comb begin
    step_nxt    = step_e;
    phase_nxt   = phase_e;
    bit_nxt     = bit_e;
    shift_nxt   = shift_e;
    slot_nxt    = slot_e;
    rx_nxt      = rx_r;
    sda_lvl_nxt = res_nxt.sda_out;
    if (step_e != i2cram_pkg::ST_IDLE) begin
      if (tick >= {1'b0, h}) begin
        phase_nxt = 8'd0;
        case (step_e)
          i2cram_pkg::ST_START_SETUP: step_nxt = i2cram_pkg::ST_START_HOLD;
          i2cram_pkg::ST_START_HOLD: begin
            if (kind == i2cram_pkg::KIND_RS) begin
              slot_nxt  = slot_inc;
              bit_nxt   = '0;
              shift_nxt = slot_load(act_nxt, slot_inc, regb_nxt, datab_nxt,
                                    cfg.device_address);
            end
            step_nxt = i2cram_pkg::ST_LO_HOLD;
          end
          i2cram_pkg::ST_LO_HOLD: step_nxt = i2cram_pkg::ST_LO_SET;
          i2cram_pkg::ST_LO_SET: begin
            if (kind == i2cram_pkg::KIND_RS) step_nxt = i2cram_pkg::ST_START_SETUP;
            else if (kind == i2cram_pkg::KIND_STOP) step_nxt = i2cram_pkg::ST_STOP_HI;
            else step_nxt = i2cram_pkg::ST_HI;
          end
          i2cram_pkg::ST_HI: begin
            if (bit_e < i2cram_pkg::BIT_IDX_W'(i2cram_pkg::BYTE_BITS)) begin
              if (kind == i2cram_pkg::KIND_RX) begin
                shift_nxt = shift_rx;
                if (bit_e == i2cram_pkg::BIT_IDX_W'(i2cram_pkg::BYTE_BITS - 1)) begin
                  rx_nxt = shift_rx;
                end
              end else begin
                shift_nxt = {shift_e[6:0], 1'b0};
              end
              bit_nxt = bit_e + i2cram_pkg::BIT_IDX_W'(1);
            end else begin
              slot_nxt  = slot_inc;
              bit_nxt   = '0;
              shift_nxt = slot_load(act_nxt, slot_inc, regb_nxt, datab_nxt,
                                    cfg.device_address);
            end
            step_nxt = i2cram_pkg::ST_LO_HOLD;
          end
          i2cram_pkg::ST_STOP_HI: step_nxt = i2cram_pkg::ST_STOP_REL;
          default:                step_nxt = i2cram_pkg::ST_IDLE;
        endcase
      end else begin
        phase_nxt = tick[7:0];
      end
    end
  end

  // engine state, advanced once per item taken from the queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r    <= i2cram_pkg::ST_IDLE;
      phase_r   <= 8'd0;
      bit_r     <= '0;
      shift_r   <= 8'd0;
      act_r     <= 1'b0;
      regb_r    <= 8'd0;
      datab_r   <= 8'd0;
      rx_r      <= 8'd0;
      slot_r    <= 3'd0;
      sda_lvl_r <= 1'b1;
    end else if (q_pop) begin
      step_r    <= step_nxt;
      phase_r   <= phase_nxt;
      bit_r     <= bit_nxt;
      shift_r   <= shift_nxt;
      act_r     <= act_nxt;
      regb_r    <= regb_nxt;
      datab_r   <= datab_nxt;
      rx_r      <= rx_nxt;
      slot_r    <= slot_nxt;
      sda_lvl_r <= sda_lvl_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'd0, res_r.read_data, res_r.done_res, res_r.busy_res,
                       res_r.sda_out, res_r.scl_out};

endmodule
`default_nettype wire

// ----- tb/sv/i2c_register_access_master_top_tb.sv -----
`default_nettype none
module i2c_register_access_master_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // one row of the directed script; ticks of zero runs until the bus is idle again
  typedef struct packed {
    logic                start_request;
    logic                action;
    logic [7:0]          reg_addr;
    logic [7:0]          wdata;
    logic                sda_in;
    logic [15:0]         ticks;
    logic                fixed;
    i2cram_pkg::result_t exp;
  } script_row_t;

  localparam logic [15:0] UNTIL_IDLE = 16'd0;
  localparam int unsigned N_ROWS     = 13;
  localparam int unsigned N_PHASES   = 3;
  localparam int unsigned PHASE_TICKS = 80;
  localparam int unsigned PAUSE_AT    = 60;
  localparam int unsigned SHORT_FROM  = 4;

  // line states that can be read straight off the protocol
  localparam i2cram_pkg::result_t IDLE_RD00  = '{scl_out:1'b1, sda_out:1'b1, busy_res:1'b0,
                                                 done_res:1'b0, read_data:8'h00};
  localparam i2cram_pkg::result_t IDLE_RDFF  = '{scl_out:1'b1, sda_out:1'b1, busy_res:1'b0,
                                                 done_res:1'b0, read_data:8'hFF};
  localparam i2cram_pkg::result_t START_RD00 = '{scl_out:1'b1, sda_out:1'b1, busy_res:1'b1,
                                                 done_res:1'b0, read_data:8'h00};
  localparam i2cram_pkg::result_t START_RDFF = '{scl_out:1'b1, sda_out:1'b1, busy_res:1'b1,
                                                 done_res:1'b0, read_data:8'hFF};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  i2c_register_access_master_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // bus engine mirror
  i2cram_pkg::step_t bus_step = i2cram_pkg::ST_IDLE;
  logic [7:0]  phase_cnt = '0;
  logic [3:0]  bit_pos = '0;
  logic [7:0]  tx_shift = '0;
  logic        lat_action = i2cram_pkg::ACT_READ;
  logic [7:0]  lat_reg = '0;
  logic [7:0]  lat_data = '0;
  logic [7:0]  rx_byte = '0;
  logic [2:0]  byte_pos = '0;
  logic        sda_last = 1'b1;
  logic [6:0]  dev_addr = i2cram_pkg::DEV_ADDR_RESET;
  logic [7:0]  half_ticks = i2cram_pkg::HALF_RESET;

  // bookkeeping
  i2cram_pkg::result_t lines_due[$];
  bit          calm = 1'b0;
  bit          paused = 1'b0;
  int unsigned sent_ticks = 0;
  int unsigned phase_ticks = 0;
  int unsigned checked = 0;
  int unsigned mismatches = 0;
  int unsigned reads_started = 0;
  int unsigned writes_started = 0;
  int unsigned stops_seen = 0;
  int unsigned rx_hold = 0;

  // what the current byte position does on the bus
  function automatic i2cram_pkg::kind_t pos_kind();
    if (lat_action == i2cram_pkg::ACT_WRITE) begin
      return (byte_pos <= 3'd2) ? i2cram_pkg::KIND_TX : i2cram_pkg::KIND_STOP;
    end
    case (byte_pos)
      3'd0, 3'd1, 3'd3: return i2cram_pkg::KIND_TX;
      3'd2: return i2cram_pkg::KIND_RS;
      3'd4: return i2cram_pkg::KIND_RX;
      default: return i2cram_pkg::KIND_STOP;
    endcase
  endfunction

  // byte shifted out at the current position
  function automatic logic [7:0] pos_byte();
    logic [7:0] waddr;
    waddr = {dev_addr, 1'b0};
    if (byte_pos == 3'd0) return waddr;
    if (byte_pos == 3'd1) return lat_reg;
    if (lat_action == i2cram_pkg::ACT_WRITE && byte_pos == 3'd2) return lat_data;
    if (lat_action == i2cram_pkg::ACT_READ && byte_pos == 3'd3) return waddr | 8'h01;
    return 8'h00;
  endfunction

  function automatic void advance_pos();
    if (byte_pos < i2cram_pkg::SLOT_LAST) byte_pos = byte_pos + 3'd1;
    bit_pos = '0;
    tx_shift = pos_byte();
  endfunction

  // sda level wanted in the low-set and high steps
  function automatic logic pos_sda();
    case (pos_kind())
      i2cram_pkg::KIND_TX:   return (bit_pos < i2cram_pkg::BYTE_BITS) ? tx_shift[7] : 1'b1;
      i2cram_pkg::KIND_STOP: return 1'b0;
      default:               return 1'b1;
    endcase
  endfunction

  // one tick of the bus engine: line drives, status and read byte
  function automatic i2cram_pkg::result_t line_model(i2cram_pkg::item_t it);
    logic        scl;
    logic        sda;
    logic        busy;
    logic        done;
    int unsigned h;
    int unsigned t;
    i2cram_pkg::kind_t k;
    h = (half_ticks == 8'd0) ? 1 : half_ticks;
    done = 1'b0;

    // request taken only while idle
    if (bus_step == i2cram_pkg::ST_IDLE && it.start_request) begin
      lat_action = it.action;
      lat_reg = it.reg_address;
      lat_data = it.write_data;
      byte_pos = '0;
      bit_pos = '0;
      tx_shift = pos_byte();
      phase_cnt = '0;
      bus_step = i2cram_pkg::ST_START_SETUP;
      if (it.action == i2cram_pkg::ACT_WRITE) writes_started++;
      else reads_started++;
    end

    // line drives for the current step
    case (bus_step)
      i2cram_pkg::ST_START_HOLD, i2cram_pkg::ST_STOP_HI: begin
        scl = 1'b1;
        sda = 1'b0;
      end
      i2cram_pkg::ST_LO_HOLD: begin
        scl = 1'b0;
        sda = sda_last;
      end
      i2cram_pkg::ST_LO_SET: begin
        scl = 1'b0;
        sda = pos_sda();
      end
      i2cram_pkg::ST_HI: begin
        scl = 1'b1;
        sda = pos_sda();
      end
      default: begin
        scl = 1'b1;
        sda = 1'b1;
      end
    endcase
    busy = (bus_step != i2cram_pkg::ST_IDLE);
    sda_last = sda;

    // step timing and sequencing
    if (busy) begin
      t = phase_cnt + 1;
      if (t >= h) begin
        phase_cnt = '0;
        case (bus_step)
          i2cram_pkg::ST_START_SETUP: bus_step = i2cram_pkg::ST_START_HOLD;
          i2cram_pkg::ST_START_HOLD: begin
            if (pos_kind() == i2cram_pkg::KIND_RS) advance_pos();
            bus_step = i2cram_pkg::ST_LO_HOLD;
          end
          i2cram_pkg::ST_LO_HOLD: bus_step = i2cram_pkg::ST_LO_SET;
          i2cram_pkg::ST_LO_SET: begin
            k = pos_kind();
            if (k == i2cram_pkg::KIND_RS) bus_step = i2cram_pkg::ST_START_SETUP;
            else if (k == i2cram_pkg::KIND_STOP) bus_step = i2cram_pkg::ST_STOP_HI;
            else bus_step = i2cram_pkg::ST_HI;
          end
          i2cram_pkg::ST_HI: begin
            k = pos_kind();
            if (bit_pos < i2cram_pkg::BYTE_BITS) begin
              if (k == i2cram_pkg::KIND_RX) begin
                tx_shift = {tx_shift[6:0], it.sda_in};
                if (bit_pos == i2cram_pkg::BYTE_BITS - 1) rx_byte = tx_shift;
              end else begin
                tx_shift = {tx_shift[6:0], 1'b0};
              end
              bit_pos = bit_pos + 4'd1;
            end else begin
              advance_pos();
            end
            bus_step = i2cram_pkg::ST_LO_HOLD;
          end
          i2cram_pkg::ST_STOP_HI: bus_step = i2cram_pkg::ST_STOP_REL;
          default: begin
            bus_step = i2cram_pkg::ST_IDLE;
            done = 1'b1;
            stops_seen++;
          end
        endcase
      end else begin
        phase_cnt = t[7:0];
      end
    end
    return '{scl_out:scl, sda_out:sda, busy_res:busy, done_res:done, read_data:rx_byte};
  endfunction

  function automatic i2cram_pkg::item_t random_item();
    i2cram_pkg::item_t it;
    it.start_request = 1'($urandom_range(0, 1));
    it.action = 1'($urandom_range(0, 1));
    it.reg_address = 8'($urandom_range(0, 255));
    it.write_data = 8'($urandom_range(0, 255));
    it.sda_in = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // send one tick, then log the line state it should produce
  task automatic drive_tick(i2cram_pkg::item_t it, logic use_fixed,
                            i2cram_pkg::result_t fixed_res);
    int unsigned gap;
    i2cram_pkg::result_t res;
    gap = calm ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {5'b0, it.sda_in, it.write_data, it.reg_address, it.action,
                 it.start_request};
    do @(posedge clk); while (!in_tready);
    res = line_model(it);
    if (use_fixed) res = fixed_res;
    lines_due.push_back(res);
    sent_ticks++;
    phase_ticks++;
  endtask

  // stop sending and let every outstanding result come back
  task automatic settle_out();
    in_tvalid <= 1'b0;
    while (lines_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // apb write, setup then access
  task automatic cfg_write(logic idx, logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (idx == i2cram_pkg::REG_DEVICE_ADDRESS) dev_addr = value[6:0];
    else half_ticks = value[7:0];
    @(posedge clk);
  endtask

  // one full bus transaction with random content and ignored requests on top
  task automatic run_transfer(logic act);
    i2cram_pkg::item_t it;
    it = random_item();
    it.start_request = 1'b1;
    it.action = act;
    drive_tick(it, 1'b0, IDLE_RD00);
    while (bus_step != i2cram_pkg::ST_IDLE) begin
      it = random_item();
      it.start_request = ($urandom_range(0, 7) == 0);
      drive_tick(it, 1'b0, IDLE_RD00);
      if (!calm && !paused && phase_ticks >= PAUSE_AT) begin
        settle_out();
        paused = 1'b1;
      end
    end
  endtask

  // result checking and receiver back-pressure
  always @(posedge clk) begin
    i2cram_pkg::result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (lines_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result %04h with nothing outstanding", out_tdata);
        end
      end else begin
        want = lines_due.pop_front();
        checked++;
        if (want.scl_out !== out_tdata[0] || want.sda_out !== out_tdata[1] ||
            want.busy_res !== out_tdata[2] || want.done_res !== out_tdata[3] ||
            want.read_data !== out_tdata[11:4]) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d: expected scl %0b sda %0b busy %0b done %0b data %02h",
                     checked, want.scl_out, want.sda_out, want.busy_res,
                     want.done_res, want.read_data);
            $display("result %0d:   actual scl %0b sda %0b busy %0b done %0b data %02h",
                     checked, out_tdata[0], out_tdata[1], out_tdata[2],
                     out_tdata[3], out_tdata[11:4]);
          end
        end
      end
    end
    if (out_tvalid && out_tready) begin
      rx_hold = calm ? 0 : (($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0);
      out_tready <= (rx_hold == 0);
    end else if (rx_hold > 0) begin
      rx_hold--;
      out_tready <= (rx_hold == 0);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // stimulus
  initial begin
    script_row_t script [N_ROWS];
    logic [6:0]  phase_dev [N_PHASES];
    logic [7:0]  phase_half [N_PHASES];
    i2cram_pkg::item_t it;
    int unsigned k;
    int unsigned n;
    int          r;
    int          p;

    // idle after reset, extremes of the fields, request while busy,
    // all-ones and all-zeros read bytes, request held high through a transaction
    script[0]  = '{1'b0, i2cram_pkg::ACT_READ,  8'h00, 8'h00, 1'b0, 16'd4,      1'b1,
                   IDLE_RD00};
    script[1]  = '{1'b1, i2cram_pkg::ACT_WRITE, 8'hFF, 8'h00, 1'b1, 16'd1,      1'b1,
                   START_RD00};
    script[2]  = '{1'b1, i2cram_pkg::ACT_READ,  8'h00, 8'hFF, 1'b0, 16'd30,     1'b0,
                   IDLE_RD00};
    script[3]  = '{1'b0, i2cram_pkg::ACT_WRITE, 8'hFF, 8'hFF, 1'b1, UNTIL_IDLE, 1'b0,
                   IDLE_RD00};
    script[4]  = '{1'b1, i2cram_pkg::ACT_WRITE, 8'h00, 8'hFF, 1'b0, 16'd1,      1'b1,
                   START_RD00};
    script[5]  = '{1'b0, i2cram_pkg::ACT_READ,  8'h00, 8'h00, 1'b0, UNTIL_IDLE, 1'b0,
                   IDLE_RD00};
    script[6]  = '{1'b1, i2cram_pkg::ACT_READ,  8'h5A, 8'h00, 1'b1, 16'd1,      1'b1,
                   START_RD00};
    script[7]  = '{1'b0, i2cram_pkg::ACT_READ,  8'h00, 8'h00, 1'b1, UNTIL_IDLE, 1'b0,
                   IDLE_RD00};
    script[8]  = '{1'b0, i2cram_pkg::ACT_READ,  8'h00, 8'h00, 1'b0, 16'd1,      1'b1,
                   IDLE_RDFF};
    script[9]  = '{1'b1, i2cram_pkg::ACT_READ,  8'hFF, 8'hFF, 1'b0, 16'd1,      1'b1,
                   START_RDFF};
    script[10] = '{1'b0, i2cram_pkg::ACT_READ,  8'h00, 8'h00, 1'b0, UNTIL_IDLE, 1'b0,
                   IDLE_RD00};
    script[11] = '{1'b0, i2cram_pkg::ACT_READ,  8'h00, 8'h00, 1'b1, 16'd1,      1'b1,
                   IDLE_RD00};
    script[12] = '{1'b1, i2cram_pkg::ACT_READ,  8'hA5, 8'h3C, 1'b1, UNTIL_IDLE, 1'b0,
                   IDLE_RD00};

    // settings per random phase: lowest address at the shortest half period,
    // highest address with a zero half period, then a random address with no idling
    phase_dev[0] = 7'd0;    phase_half[0] = 8'd1;
    phase_dev[1] = 7'd127;  phase_half[1] = 8'd0;
    phase_dev[2] = 7'($urandom_range(0, 127)); phase_half[2] = 8'($urandom_range(1, 2));

    // reset
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed script, first write at reset settings, the rest at the shortest half period
    for (r = 0; r < N_ROWS; r++) begin
      if (r == SHORT_FROM) begin
        settle_out();
        cfg_write(i2cram_pkg::REG_HALF_PERIOD, 32'd1);
      end
      it = '{script[r].start_request, script[r].action, script[r].reg_addr,
             script[r].wdata, script[r].sda_in};
      k = 0;
      do begin
        drive_tick(it, script[r].fixed && k == 0, script[r].exp);
        k++;
      end while ((script[r].ticks == UNTIL_IDLE) ? (bus_step != i2cram_pkg::ST_IDLE) :
                 (k < script[r].ticks));
    end

    // random phases, each under its own settings
    for (p = 0; p < N_PHASES; p++) begin
      settle_out();
      cfg_write(i2cram_pkg::REG_DEVICE_ADDRESS, {25'b0, phase_dev[p]});
      cfg_write(i2cram_pkg::REG_HALF_PERIOD, {24'b0, phase_half[p]});
      calm = (p == N_PHASES - 1);
      paused = 1'b0;
      phase_ticks = 0;
      while (phase_ticks < PHASE_TICKS) begin
        run_transfer(1'($urandom_range(0, 1)));
        n = $urandom_range(0, 4);
        repeat (n) begin
          it = random_item();
          it.start_request = 1'b0;
          drive_tick(it, 1'b0, IDLE_RD00);
        end
      end
    end

    // drain and report
    calm = 1'b0;
    settle_out();
    repeat (16) @(posedge clk);
    $display("sent %0d bus ticks over %0d settings, %0d results checked",
             sent_ticks, N_PHASES + 2, checked);
    $display("%0d reads and %0d writes started, %0d stop conditions, %0d mismatches",
             reads_started, writes_started, stops_seen, mismatches);
    if (mismatches == 0 && lines_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
